/* rtl/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg
// Shared widths, constants and the block snapshot type of the level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package slm_pkg;

	localparam int SMP_W = 16;
	localparam int CNT_W = 12;              // holds any frame limit up to 4095
	localparam int SUM_W = 31 + CNT_W;      // 2^30 per frame times the limit
	localparam int DIV_W = SUM_W + 16;      // dividend is the sum times 2^16
	localparam int Q_W   = 47;              // mean square never exceeds 2^46
	localparam int LVL_W = 25;

	localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

	localparam logic signed [LVL_W-1:0] RMS_FLOOR = 25'sd8;
	localparam logic signed [LVL_W-1:0] DB_FLOOR  = -25'sd30720;
	localparam logic [17:0]             DB_PER_LOG2 = 18'd197283;

	localparam logic [1:0] REG_LEVEL_MODE = 2'd0;
	localparam logic [1:0] REG_STEREO     = 2'd1;

	// Bit 1 of the mode selects peak, bit 0 selects decibels in RMS.
	localparam int MODE_DB_BIT   = 0;
	localparam int MODE_PEAK_BIT = 1;

	typedef struct packed {
		logic [SUM_W-1:0]        sum_l;
		logic [SUM_W-1:0]        sum_r;
		logic signed [SMP_W-1:0] hi_l;
		logic signed [SMP_W-1:0] lo_l;
		logic signed [SMP_W-1:0] hi_r;
		logic signed [SMP_W-1:0] lo_r;
		logic [CNT_W-1:0]        n;
		logic [1:0]              mode;
		logic                    stereo;
	} snap_t;

endpackage

`default_nettype wire

/* rtl/slm_front.sv */
// ----------------------------------------------------------------------------
// slm_front
// Accepts frames, accumulates squares and peaks, and hands a snapshot of the
// block to the queue on the final frame.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_front #(
	parameter int BLOCK_FRAMES_MAX = 1023
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [slm_pkg::SMP_W-1:0] left_sample,
	input  wire logic signed [slm_pkg::SMP_W-1:0] right_sample,
	input  wire logic                            block_end,
	input  wire logic [1:0]                      level_mode,
	input  wire logic                            stereo,
	input  wire logic                            full,
	output logic                                 push,
	output slm_pkg::snap_t                       snap
);
	import slm_pkg::*;

	logic [SUM_W-1:0]        sum_l_q, sum_r_q, sum_l_nx, sum_r_nx;
	logic signed [SMP_W-1:0] hi_l_q, lo_l_q, hi_r_q, lo_r_q;
	logic signed [SMP_W-1:0] hi_l_nx, lo_l_nx, hi_r_nx, lo_r_nx;
	logic [CNT_W-1:0]        n_q, n_nx;
	logic signed [31:0]      lsq, rsq;
	logic                    take, acc;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;
	assign push     = acc && block_end;
	assign take     = n_q < CNT_W'(BLOCK_FRAMES_MAX);

	assign lsq = left_sample * left_sample;
	assign rsq = right_sample * right_sample;

	always_comb begin
		sum_l_nx = sum_l_q;
		sum_r_nx = sum_r_q;
		hi_l_nx  = hi_l_q;
		lo_l_nx  = lo_l_q;
		hi_r_nx  = hi_r_q;
		lo_r_nx  = lo_r_q;
		n_nx     = n_q;
		if (take) begin
			sum_l_nx = sum_l_q + SUM_W'($unsigned(lsq));
			sum_r_nx = sum_r_q + SUM_W'($unsigned(rsq));
			if (left_sample > hi_l_q) hi_l_nx = left_sample;
			if (left_sample < lo_l_q) lo_l_nx = left_sample;
			if (right_sample > hi_r_q) hi_r_nx = right_sample;
			if (right_sample < lo_r_q) lo_r_nx = right_sample;
			n_nx = n_q + 1'b1;
		end
	end

	always_comb begin
		snap.sum_l  = sum_l_nx;
		snap.sum_r  = sum_r_nx;
		snap.hi_l   = hi_l_nx;
		snap.lo_l   = lo_l_nx;
		snap.hi_r   = hi_r_nx;
		snap.lo_r   = lo_r_nx;
		snap.n      = n_nx;
		snap.mode   = level_mode;
		snap.stereo = stereo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_l_q <= '0;
			sum_r_q <= '0;
			hi_l_q  <= SMP_MIN;
			lo_l_q  <= SMP_MAX;
			hi_r_q  <= SMP_MIN;
			lo_r_q  <= SMP_MAX;
			n_q     <= '0;
		end else if (acc) begin
			if (block_end) begin
				sum_l_q <= '0;
				sum_r_q <= '0;
				hi_l_q  <= SMP_MIN;
				lo_l_q  <= SMP_MAX;
				hi_r_q  <= SMP_MIN;
				lo_r_q  <= SMP_MAX;
				n_q     <= '0;
			end else begin
				sum_l_q <= sum_l_nx;
				sum_r_q <= sum_r_nx;
				hi_l_q  <= hi_l_nx;
				lo_l_q  <= lo_l_nx;
				hi_r_q  <= hi_r_nx;
				lo_r_q  <= lo_r_nx;
				n_q     <= n_nx;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/slm_queue.sv */
// ----------------------------------------------------------------------------
// slm_queue
// Two-entry queue of block snapshots between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  slm_pkg::snap_t      din,
	output logic                full,
	input  wire logic           pop,
	output logic                avail,
	output slm_pkg::snap_t      dout
);
	import slm_pkg::*;

	snap_t      entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign avail = count_q != 2'd0;
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("snapshot pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail) else $error("snapshot popped from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* rtl/slm_back.sv */
// ----------------------------------------------------------------------------
// slm_back
// Turns a block snapshot into a result: peak check, or per channel a serial
// divide for the mean square followed by a serial square root or log2.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             avail,
	input  slm_pkg::snap_t                        snap_in,
	output logic                                  pop,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [slm_pkg::LVL_W-1:0]      left_level,
	output logic signed [slm_pkg::LVL_W-1:0]      right_level,
	output logic signed [slm_pkg::SMP_W-1:0]      left_trough,
	output logic signed [slm_pkg::SMP_W-1:0]      right_trough,
	output logic                                  status
);
	import slm_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_LOAD = 10'b00_0000_0010,
		S_DIV  = 10'b00_0000_0100,
		S_SQRT = 10'b00_0000_1000,
		S_NORM = 10'b00_0001_0000,
		S_LMUL = 10'b00_0010_0000,
		S_LADJ = 10'b00_0100_0000,
		S_DMUL = 10'b00_1000_0000,
		S_DFIN = 10'b01_0000_0000,
		S_NEXT = 10'b10_0000_0000
	} state_t;

	localparam int CNT_BITS = $clog2(DIV_W);

	state_t                  state_q;
	snap_t                   job_q;
	logic                    chan_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [CNT_W-1:0]        rem_q;
	logic [DIV_W-1:0]        dvd_q;
	logic [Q_W-1:0]          quo_q;
	logic [47:0]             src_q;
	logic [25:0]             sqrem_q;
	logic [23:0]             root_q;
	logic [5:0]              e_q;
	logic [30:0]             m_q;
	logic [15:0]             frac_q;
	logic [61:0]             prod_q;
	logic signed [LVL_W-1:0] lvl_l_q, lvl_r_q;

	logic                    out_valid_q, status_q;
	logic signed [LVL_W-1:0] out_l_q, out_r_q;
	logic signed [SMP_W-1:0] out_lt_q, out_rt_q;

	logic [CNT_W:0]          div_r2;
	logic                    div_ge;
	logic [27:0]             sq_r2;
	logic [25:0]             sq_trial;
	logic                    sq_ge;
	logic [31:0]             lg_t;
	logic [21:0]             neg;
	logic [16:0]             db_mag;
	logic                    peak_bad;
	logic signed [LVL_W-1:0] lvl_new, root_lvl, db_lvl;

	assign out_valid    = out_valid_q;
	assign left_level   = out_l_q;
	assign right_level  = out_r_q;
	assign left_trough  = out_lt_q;
	assign right_trough = out_rt_q;
	assign status       = status_q;

	assign pop = (state_q == S_IDLE) && avail && !out_valid_q;

	assign div_r2 = {rem_q, dvd_q[DIV_W-1]};
	assign div_ge = div_r2 >= {1'b0, job_q.n};

	assign sq_r2    = {sqrem_q, src_q[47:46]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = sq_r2 >= {2'b00, sq_trial};

	assign lg_t   = prod_q[61:30];
	assign neg    = {6'(6'd46 - e_q), 16'h0000} - {6'b0, frac_q};
	assign db_mag = 17'((prod_q + 62'd8388608) >> 24);

	assign root_lvl = (root_q < 24'd8) ? RMS_FLOOR : LVL_W'({1'b0, root_q});
	assign db_lvl   = (db_mag > 17'd30720) ? DB_FLOOR : -$signed({8'b0, db_mag});

	assign peak_bad = (snap_in.n == '0) || (snap_in.hi_l == SMP_MIN) ||
		(snap_in.lo_l == SMP_MIN) ||
		(snap_in.stereo && ((snap_in.hi_r == SMP_MIN) || (snap_in.lo_r == SMP_MIN)));

	always_comb begin
		case (state_q)
			S_DIV:   lvl_new = DB_FLOOR;
			S_SQRT:  lvl_new = root_lvl;
			default: lvl_new = db_lvl;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop) job_q <= snap_in;
			end
			S_LOAD: begin
				dvd_q <= {chan_q ? job_q.sum_r : job_q.sum_l, 16'h0000};
				rem_q <= '0;
				quo_q <= '0;
			end
			S_DIV: begin
				rem_q <= CNT_W'(div_ge ? div_r2 - {1'b0, job_q.n} : div_r2);
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[Q_W-2:0], div_ge};
				if (cnt_q == '0) begin
					e_q     <= 6'd46;
					src_q   <= {1'b0, quo_q[Q_W-2:0], div_ge};
					sqrem_q <= '0;
					root_q  <= '0;
				end
			end
			S_SQRT: begin
				sqrem_q <= sq_ge ? 26'(sq_r2 - {2'b00, sq_trial}) : sq_r2[25:0];
				root_q  <= {root_q[22:0], sq_ge};
				src_q   <= src_q << 2;
			end
			S_NORM: begin
				if (quo_q[Q_W-1]) begin
					m_q    <= quo_q[Q_W-1:Q_W-31];
					frac_q <= '0;
				end else begin
					quo_q <= quo_q << 1;
					e_q   <= e_q - 6'd1;
				end
			end
			S_LMUL: prod_q <= 62'(m_q * m_q);
			S_LADJ: begin
				// A square at or above two shifts the mantissa and emits a one.
				if (lg_t[31]) begin
					m_q <= lg_t[31:1];
					frac_q[cnt_q[3:0]] <= 1'b1;
				end else begin
					m_q <= lg_t[30:0];
				end
			end
			S_DMUL: prod_q <= 62'(neg * DB_PER_LOG2);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chan_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
			out_lt_q    <= '0;
			out_rt_q    <= '0;
			lvl_l_q     <= '0;
			lvl_r_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						chan_q <= 1'b0;
						if (snap_in.mode[MODE_PEAK_BIT]) begin
							out_valid_q <= 1'b1;
							status_q    <= peak_bad;
							out_l_q     <= peak_bad ? '0 : LVL_W'(snap_in.hi_l);
							out_lt_q    <= peak_bad ? '0 : snap_in.lo_l;
							out_r_q     <= (peak_bad || !snap_in.stereo) ? '0
								: LVL_W'(snap_in.hi_r);
							out_rt_q    <= (peak_bad || !snap_in.stereo) ? '0
								: snap_in.lo_r;
						end else if (snap_in.n == '0) begin
							out_valid_q <= 1'b1;
							status_q    <= 1'b1;
							out_l_q     <= '0;
							out_r_q     <= '0;
							out_lt_q    <= '0;
							out_rt_q    <= '0;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					cnt_q   <= CNT_BITS'(DIV_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						if (!job_q.mode[MODE_DB_BIT]) begin
							cnt_q   <= CNT_BITS'(23);
							state_q <= S_SQRT;
						end else if ({quo_q[Q_W-2:0], div_ge} == '0) begin
							if (chan_q) lvl_r_q <= lvl_new;
							else lvl_l_q <= lvl_new;
							state_q <= S_NEXT;
						end else begin
							state_q <= S_NORM;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= S_NEXT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_NORM: begin
					if (quo_q[Q_W-1]) begin
						cnt_q   <= CNT_BITS'(15);
						state_q <= S_LMUL;
					end
				end
				S_LMUL: state_q <= S_LADJ;
				S_LADJ: begin
					if (cnt_q == '0) begin
						state_q <= S_DMUL;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_LMUL;
					end
				end
				S_DMUL: state_q <= S_DFIN;
				S_DFIN: begin
					if (chan_q) lvl_r_q <= lvl_new;
					else lvl_l_q <= lvl_new;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (!job_q.mode[MODE_DB_BIT]) begin
						// Linear results arrive here straight from the root register.
						if (chan_q) lvl_r_q <= root_lvl;
						else lvl_l_q <= root_lvl;
					end
					if (!chan_q && job_q.stereo) begin
						chan_q  <= 1'b1;
						state_q <= S_LOAD;
					end else begin
						out_valid_q <= 1'b1;
						status_q    <= 1'b0;
						out_lt_q    <= '0;
						out_rt_q    <= '0;
						out_l_q     <= (!chan_q && !job_q.mode[MODE_DB_BIT]) ? root_lvl
							: lvl_l_q;
						if (!job_q.stereo) begin
							out_r_q <= job_q.mode[MODE_DB_BIT] ? DB_FLOOR : RMS_FLOOR;
						end else begin
							out_r_q <= job_q.mode[MODE_DB_BIT] ? lvl_r_q : root_lvl;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/stereo_audio_level_meter_unit.sv */
// ----------------------------------------------------------------------------
// stereo_audio_level_meter_unit
// RMS, decibel or peak level of blocks of 16-bit PCM frames.
// ----------------------------------------------------------------------------
// Frames enter on the in_valid/in_ready channel, one transfer per clock while
// in_ready is high; the frame whose block_end is set closes the block and
// yields one result on the out_valid/out_ready channel. Configuration is
// written through cfg_write, cfg_index and cfg_data; the user must do so
// only while the block is idle, which the unit does not enforce. A closed
// block waits in a two-entry queue for the result engine, which works one
// channel at a time: a bit-serial divide over the DIV_W (59) dividend bits,
// then a serial square root for the linear level, or normalization, a log2
// by repeated squaring and a scaling for decibels. A peak or empty block is
// answered directly from the idle state, without the engine.
// in_ready drops only while the queue holds two closed blocks, so frames keep
// flowing while a result waits on a stalled receiver. Reset empties the
// queue, clears all block state and sets RMS linear mode in stereo.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_audio_level_meter_unit #(
	parameter int BLOCK_FRAMES_MAX = 1023
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [1:0]                       cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [slm_pkg::SMP_W-1:0] left_sample,
	input  wire logic signed [slm_pkg::SMP_W-1:0] right_sample,
	input  wire logic                             block_end,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [slm_pkg::LVL_W-1:0]      left_level,
	output logic signed [slm_pkg::LVL_W-1:0]      right_level,
	output logic signed [slm_pkg::SMP_W-1:0]      left_trough,
	output logic signed [slm_pkg::SMP_W-1:0]      right_trough,
	output logic                                  status
);
	import slm_pkg::*;

	logic [1:0] level_mode_q;
	logic       stereo_q;
	logic       push, full, pop, avail;
	snap_t      snap_wr, snap_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_mode_q <= 2'd0;
			stereo_q     <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LEVEL_MODE: level_mode_q <= cfg_data;
				REG_STEREO:     stereo_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	slm_front #(
		.BLOCK_FRAMES_MAX(BLOCK_FRAMES_MAX)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.left_sample (left_sample),
		.right_sample(right_sample),
		.block_end   (block_end),
		.level_mode  (level_mode_q),
		.stereo      (stereo_q),
		.full        (full),
		.push        (push),
		.snap        (snap_wr)
	);

	slm_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (snap_wr),
		.full  (full),
		.pop   (pop),
		.avail (avail),
		.dout  (snap_rd)
	);

	slm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (avail),
		.snap_in     (snap_rd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_level  (left_level),
		.right_level (right_level),
		.left_trough (left_trough),
		.right_trough(right_trough),
		.status      (status)
	);

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the stereo audio level meter.
// ----------------------------------------------------------------------------
// Frames are streamed into the meter under random idling on both channels.
// A local model of the accumulator and of the RMS, decibel and peak result
// math predicts each block result. Every result transfer is then checked
// field by field against the oldest prediction. Directed tests cover full
// scale, silence, clipping rejection, mono operation, the frame limit and
// the unused mode and register codes. Random blocks of mostly short length
// follow. One phase stalls the receiver long enough to block the input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import slm_pkg::*;

	localparam logic [1:0] MODE_RMS      = 2'd0;
	localparam logic [1:0] MODE_DB       = 2'd1;
	localparam logic [1:0] MODE_PEAK     = 2'd2;
	localparam logic [1:0] REG_SPARE_A   = 2'd2;
	localparam logic [1:0] REG_SPARE_B   = 2'd3;
	localparam int         FRAME_LIMIT   = 1023;
	localparam int         SETTLE_CYCLES = 400;
	localparam int         CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic signed [LVL_W-1:0] level_l;
		logic signed [LVL_W-1:0] level_r;
		logic signed [SMP_W-1:0] trough_l;
		logic signed [SMP_W-1:0] trough_r;
		logic                    status;
	} level_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [1:0]              cfg_index = '0;
	logic [1:0]              cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [SMP_W-1:0] left_sample = '0;
	logic signed [SMP_W-1:0] right_sample = '0;
	logic                    block_end = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [LVL_W-1:0] left_level;
	logic signed [LVL_W-1:0] right_level;
	logic signed [SMP_W-1:0] left_trough;
	logic signed [SMP_W-1:0] right_trough;
	logic                    status;

	stereo_audio_level_meter_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.left_sample(left_sample), .right_sample(right_sample),
		.block_end(block_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_level(left_level), .right_level(right_level),
		.left_trough(left_trough), .right_trough(right_trough),
		.status(status)
	);

	always #10 clk = ~clk;

	// Model state of the meter.
	logic [1:0]              meter_mode = MODE_RMS;
	logic                    meter_stereo = 1'b1;
	longint unsigned         sq_sum_l, sq_sum_r;
	logic signed [SMP_W-1:0] peak_hi_l, peak_lo_l, peak_hi_r, peak_lo_r;
	int                      frames_in_block;

	level_result_t pending_levels[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int frames_sent = 0;
	int blocks_checked = 0;
	int mismatches = 0;
	int rejects_seen = 0;

	function automatic void clear_block();
		sq_sum_l = 0;
		sq_sum_r = 0;
		peak_hi_l = SMP_MIN;
		peak_lo_l = SMP_MAX;
		peak_hi_r = SMP_MIN;
		peak_lo_r = SMP_MAX;
		frames_in_block = 0;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic signed [LVL_W-1:0] level_linear(longint unsigned q);
		longint unsigned r;
		r = int_sqrt(q);
		if (r < 8)
			return RMS_FLOOR;
		return LVL_W'(r);
	endfunction

	// Log2 in Q16 by repeated squaring of the Q30 mantissa, then scaled to dB Q8.8.
	function automatic logic signed [LVL_W-1:0] level_db(longint unsigned q);
		int              e;
		longint unsigned m;
		longint unsigned lg;
		longint unsigned neg;
		longint          db;
		if (q == 0)
			return DB_FLOOR;
		e = 0;
		while (e < 63 && (q >> (e + 1)) != 0)
			e++;
		m = (e <= 30) ? (q << (30 - e)) : (q >> (e - 30));
		lg = longint'(e) << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				lg = lg | (64'd1 << i);
			end
		end
		neg = (64'd46 << 16) - lg;
		db = -longint'((neg * 64'd197283 + (64'd1 << 23)) >> 24);
		if (db < -30720)
			db = -30720;
		return LVL_W'(db);
	endfunction

	// Applies one accepted frame; returns 1 and the block result on the last frame.
	function automatic bit meter_frame(input logic signed [SMP_W-1:0] l,
			input logic signed [SMP_W-1:0] r, input logic last,
			output level_result_t res);
		longint unsigned ql, qr;
		bit              bad;
		res = '0;
		if (frames_in_block < FRAME_LIMIT) begin
			sq_sum_l += longint'(l) * longint'(l);
			sq_sum_r += longint'(r) * longint'(r);
			if (l > peak_hi_l) peak_hi_l = l;
			if (l < peak_lo_l) peak_lo_l = l;
			if (r > peak_hi_r) peak_hi_r = r;
			if (r < peak_lo_r) peak_lo_r = r;
			frames_in_block++;
		end
		if (!last)
			return 0;
		if (meter_mode[MODE_PEAK_BIT]) begin
			bad = frames_in_block == 0 || peak_hi_l == SMP_MIN || peak_lo_l == SMP_MIN;
			if (meter_stereo && (peak_hi_r == SMP_MIN || peak_lo_r == SMP_MIN))
				bad = 1;
			if (bad) begin
				res.status = 1'b1;
			end else begin
				res.level_l = LVL_W'(peak_hi_l);
				res.trough_l = peak_lo_l;
				if (meter_stereo) begin
					res.level_r = LVL_W'(peak_hi_r);
					res.trough_r = peak_lo_r;
				end
			end
		end else if (frames_in_block == 0) begin
			res.status = 1'b1;
		end else begin
			ql = (sq_sum_l << 16) / longint'(frames_in_block);
			qr = (sq_sum_r << 16) / longint'(frames_in_block);
			if (meter_mode[MODE_DB_BIT]) begin
				res.level_l = level_db(ql);
				res.level_r = meter_stereo ? level_db(qr) : DB_FLOOR;
			end else begin
				res.level_l = level_linear(ql);
				res.level_r = meter_stereo ? level_linear(qr) : RMS_FLOOR;
			end
		end
		clear_block();
		return 1;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk)
		if (hold_left > 0)
			hold_left <= hold_left - 1;

	always @(posedge clk)
		out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

	task automatic report_mismatch(input string what, input longint expected_val,
			input longint actual_val);
		mismatches++;
		if (mismatches <= 10)
			$display("tb: block %0d %s expected %0d got %0d", blocks_checked, what,
				expected_val, actual_val);
	endtask

	always @(posedge clk) begin : check_results
		level_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				report_mismatch("unexpected result, status", 0, status);
			end else begin
				exp_res = pending_levels.pop_front();
				if (left_level !== exp_res.level_l)
					report_mismatch("left_level", exp_res.level_l, left_level);
				if (right_level !== exp_res.level_r)
					report_mismatch("right_level", exp_res.level_r, right_level);
				if (left_trough !== exp_res.trough_l)
					report_mismatch("left_trough", exp_res.trough_l, left_trough);
				if (right_trough !== exp_res.trough_r)
					report_mismatch("right_trough", exp_res.trough_r, right_trough);
				if (status !== exp_res.status)
					report_mismatch("status", exp_res.status, status);
				if (exp_res.status)
					rejects_seen++;
			end
			blocks_checked++;
		end
	end

	// Offers one frame and waits for its transfer; called at a rising edge.
	task automatic send_frame(input logic signed [SMP_W-1:0] l,
			input logic signed [SMP_W-1:0] r, input logic last);
		level_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		block_end <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		frames_sent++;
		if (meter_frame(l, r, last, res))
			pending_levels = {pending_levels, res};
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_write high; the caller lowers it after its last write.
	task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_LEVEL_MODE)
			meter_mode = data;
		else if (idx == REG_STEREO)
			meter_stereo = data[0];
	endtask

	task automatic configure(input logic [1:0] mode, input logic two_ch);
		drain();
		write_reg(REG_LEVEL_MODE, mode);
		write_reg(REG_STEREO, {1'b0, two_ch});
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_block(input int len, input int kind);
		logic signed [SMP_W-1:0] l, r;
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: begin
					l = SMP_W'($urandom);
					r = SMP_W'($urandom);
				end
				1: begin
					l = $signed(SMP_W'($urandom_range(6))) - 16'sd3;
					r = $signed(SMP_W'($urandom_range(6))) - 16'sd3;
				end
				2: begin
					l = '0;
					r = '0;
				end
				default: begin
					l = ($urandom_range(9) == 0) ? SMP_MIN : SMP_W'($urandom);
					r = ($urandom_range(9) == 0) ? SMP_MIN : SMP_W'($urandom);
				end
			endcase
			send_frame(l, r, i == len - 1);
		end
	endtask

	task automatic test_directed();
		// Full scale in every mode, in stereo and mono, and silence in stereo.
		for (int m = 0; m < 4; m++) begin
			configure(m[1:0], 1'b1);
			send_frame(SMP_MAX, SMP_MIN, 1'b1);
			send_frame(16'sd0, 16'sd0, 1'b1);
			send_frame(16'sd1, -16'sd1, 1'b0);
			send_frame(SMP_MAX, 16'sd5, 1'b1);
			configure(m[1:0], 1'b0);
			send_frame(-16'sd7, SMP_MIN, 1'b1);
			send_frame(SMP_MIN, 16'sd3, 1'b1);
		end
		// Writes to unused register indexes must leave the setup alone.
		drain();
		write_reg(REG_SPARE_A, 2'b11);
		write_reg(REG_SPARE_B, 2'b10);
		cfg_write <= 1'b0;
		@(posedge clk);
		send_frame(16'sd100, -16'sd200, 1'b1);
	endtask

	task automatic test_frame_limit();
		configure(MODE_RMS, 1'b1);
		send_block(FRAME_LIMIT + 8, 0);
		configure(MODE_PEAK, 1'b1);
		for (int i = 0; i < FRAME_LIMIT + 3; i++)
			send_frame((i >= FRAME_LIMIT) ? SMP_MIN : 16'sd9, 16'sd4,
				i == FRAME_LIMIT + 2);
	endtask

	// The mode is taken when the block closes, not when it opens.
	task automatic test_mode_mid_block();
		configure(MODE_PEAK, 1'b1);
		send_frame(16'sd1000, -16'sd1000, 1'b0);
		send_frame(-16'sd50, 16'sd60, 1'b0);
		configure(MODE_DB, 1'b0);
		send_frame(16'sd20000, 16'sd7, 1'b1);
	endtask

	task automatic test_random(input int frames, input int send_pct, input int recv_pct);
		int goal;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		goal = frames_sent + frames;
		while (frames_sent < goal) begin
			configure(2'($urandom_range(3)), 1'($urandom_range(1)));
			for (int b = 0; b < 4; b++)
				send_block(($urandom_range(7) == 0) ? $urandom_range(40, 200)
					: $urandom_range(1, 12), $urandom_range(3));
		end
	endtask

	task automatic test_backpressure();
		configure(MODE_DB, 1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left <= 3000;
		@(posedge clk);
		for (int b = 0; b < 40; b++)
			send_block($urandom_range(1, 3), 0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		clear_block();
		@(posedge clk);
		send_idle_pct = 10;
		recv_stall_pct = 53;
		test_directed();
		test_frame_limit();
		test_mode_mid_block();
		test_random(150, 10, 53);
		test_random(150, 53, 10);
		test_random(150, 0, 0);
		test_backpressure();
		drain();
		$display("tb: %0d frames sent, %0d block results checked, %0d rejected",
			frames_sent, blocks_checked, rejects_seen);
		$display("tb: modes RMS, dB and peak in stereo and mono, frame limit, stalls");
		if (mismatches == 0 && pending_levels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
